/* rtl/rtpl_pkg.sv */
// shared types and constants for the routed track path length block
`default_nettype none

package rtpl_pkg;

    // width and ceiling of the path length result
    localparam int LEN_BITS = 17;
    localparam logic [LEN_BITS-1:0] LEN_MAX = {LEN_BITS{1'b1}};

    // length added when a group closes, and for a final single-track group
    localparam int GROUP_STEP = 2;
    localparam int SINGLE_STEP = 1;

    // paths this short report their track count
    localparam int SHORT_PATH = 2;

    // control bits of one track passed from the input stage to the core
    typedef struct packed {
        logic vertical;
        logic last;
    } track_ctrl_t;

endpackage

`default_nettype wire

/* rtl/rtpl_track_stage.sv */
// input register stage holding one track transaction
`default_nettype none

module rtpl_track_stage #(
    parameter int COORD_BITS = 10
) (
    input  wire                       clk,
    input  wire                       rst_n,
    input  wire                       in_valid,
    output logic                      in_ready,
    input  wire  [COORD_BITS-1:0]     track_row,
    input  wire  [COORD_BITS-1:0]     track_col,
    input  wire                       track_vertical,
    input  wire                       last_track,
    input  wire                       take,
    output logic                      stage_valid,
    output logic [COORD_BITS-1:0]     stage_row,
    output logic [COORD_BITS-1:0]     stage_col,
    output rtpl_pkg::track_ctrl_t     stage_ctrl
);

    logic                  valid_reg;
    logic                  valid_next;
    logic [COORD_BITS-1:0] row_reg;
    logic [COORD_BITS-1:0] col_reg;
    rtpl_pkg::track_ctrl_t ctrl_reg;
    logic                  load;

    // the stage refills whenever it is empty or its track moves on
    assign in_ready   = !valid_reg || take;
    assign load       = in_valid && in_ready;
    assign valid_next = load ? 1'b1 : (take ? 1'b0 : valid_reg);

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            row_reg           <= track_row;
            col_reg           <= track_col;
            ctrl_reg.vertical <= track_vertical;
            ctrl_reg.last     <= last_track;
        end
    end

    assign stage_valid = valid_reg;
    assign stage_row   = row_reg;
    assign stage_col   = col_reg;
    assign stage_ctrl  = ctrl_reg;

endmodule

`default_nettype wire

/* rtl/rtpl_length_core.sv */
// shared box tracking, length accumulation and result register
`default_nettype none

module rtpl_length_core #(
    parameter int COORD_BITS = 10,
    parameter int COUNT_BITS = 16
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              stage_valid,
    input  wire  [COORD_BITS-1:0]            stage_row,
    input  wire  [COORD_BITS-1:0]            stage_col,
    input  wire  rtpl_pkg::track_ctrl_t      stage_ctrl,
    input  wire                              count_every_track,
    output logic                             take,
    output logic                             out_valid,
    input  wire                              out_ready,
    output logic [rtpl_pkg::LEN_BITS-1:0]    path_len
);

    localparam int LEN_BITS  = rtpl_pkg::LEN_BITS;
    localparam int WIDE_BITS = ((COUNT_BITS > LEN_BITS) ? COUNT_BITS : LEN_BITS) + 1;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    // shared box set
    logic [1:0]                  box_valid_reg;
    logic [1:0]                  box_valid_next;
    logic [1:0][COORD_BITS-1:0]  box_row_reg;
    logic [1:0][COORD_BITS-1:0]  box_row_next;
    logic [1:0][COORD_BITS-1:0]  box_col_reg;
    logic [1:0][COORD_BITS-1:0]  box_col_next;
    logic                        many_reg;
    logic                        many_next;
    logic [LEN_BITS-1:0]         len_reg;
    logic [LEN_BITS-1:0]         len_next;
    logic [COUNT_BITS-1:0]       count_reg;
    logic [COUNT_BITS-1:0]       count_next;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic [LEN_BITS-1:0]         path_len_reg;
    logic [LEN_BITS-1:0]         path_len_next;

    // boxes touched by the current track
    logic [COORD_BITS-1:0]       tb1_row;
    logic [COORD_BITS-1:0]       tb1_col;
    logic                        tb1_valid;
    logic [1:0]                  keep;
    logic                        fire;
    logic                        restart;
    logic [LEN_BITS:0]           len_plus;
    logic [LEN_BITS-1:0]         len_upd;
    logic [COUNT_BITS-1:0]       count_upd;
    logic [LEN_BITS:0]           grouped_len;
    logic [WIDE_BITS-1:0]        result_wide;

    // a track moves on unless it would produce a result into a full output register that is not being read
    assign take = !stage_ctrl.last || !out_valid_reg || out_ready;
    assign fire = stage_valid && take;

    // second box: left neighbor for horizontal, upper neighbor for vertical
    always_comb
    begin
        if (stage_ctrl.vertical)
        begin
            tb1_row   = stage_row - COORD_BITS'(1);
            tb1_col   = stage_col;
            tb1_valid = (stage_row != '0);
        end
        else
        begin
            tb1_row   = stage_row;
            tb1_col   = stage_col - COORD_BITS'(1);
            tb1_valid = (stage_col != '0);
        end
    end

    // which shared boxes the track also touches
    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            keep[i] = box_valid_reg[i] &&
                      (((box_row_reg[i] == stage_row) && (box_col_reg[i] == stage_col)) ||
                       (tb1_valid && (box_row_reg[i] == tb1_row) &&
                        (box_col_reg[i] == tb1_col)));
        end
    end

    assign restart   = (count_reg == '0) || (keep == 2'b00);
    assign len_plus  = {1'b0, len_reg} + (LEN_BITS+1)'(rtpl_pkg::GROUP_STEP);
    assign count_upd = (count_reg == COUNT_MAX) ? count_reg : count_reg + COUNT_BITS'(1);

    // length after a group closes, saturating
    always_comb
    begin
        if (count_reg == '0)
        begin
            len_upd = len_reg;
        end
        else if (keep != 2'b00)
        begin
            len_upd = len_reg;
        end
        else if (len_plus > {1'b0, rtpl_pkg::LEN_MAX})
        begin
            len_upd = rtpl_pkg::LEN_MAX;
        end
        else
        begin
            len_upd = len_plus[LEN_BITS-1:0];
        end
    end

    // grouped result and choice against the track count
    always_comb
    begin
        grouped_len = {1'b0, len_upd} +
                      (restart ? (LEN_BITS+1)'(rtpl_pkg::SINGLE_STEP)
                               : (LEN_BITS+1)'(rtpl_pkg::GROUP_STEP));
        if (count_every_track || (count_upd <= COUNT_BITS'(rtpl_pkg::SHORT_PATH)))
        begin
            result_wide = WIDE_BITS'(count_upd);
        end
        else
        begin
            result_wide = WIDE_BITS'(grouped_len);
        end
        if (result_wide > WIDE_BITS'(rtpl_pkg::LEN_MAX))
        begin
            path_len_next = rtpl_pkg::LEN_MAX;
        end
        else
        begin
            path_len_next = result_wide[LEN_BITS-1:0];
        end
    end

    // next path state
    always_comb
    begin
        box_valid_next = box_valid_reg;
        box_row_next   = box_row_reg;
        box_col_next   = box_col_reg;
        many_next      = many_reg;
        len_next       = len_reg;
        count_next     = count_reg;
        if (fire)
        begin
            if (stage_ctrl.last)
            begin
                box_valid_next = 2'b00;
                many_next      = 1'b0;
                len_next       = '0;
                count_next     = '0;
            end
            else
            begin
                count_next = count_upd;
                len_next   = len_upd;
                if (restart)
                begin
                    box_valid_next  = {tb1_valid, 1'b1};
                    box_row_next[0] = stage_row;
                    box_col_next[0] = stage_col;
                    box_row_next[1] = tb1_row;
                    box_col_next[1] = tb1_col;
                    many_next       = 1'b0;
                end
                else
                begin
                    box_valid_next = keep;
                    many_next      = 1'b1;
                end
            end
        end
    end

    // result register handshake
    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        if (fire && stage_ctrl.last)
        begin
            out_valid_next = 1'b1;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_valid_reg <= 2'b00;
            many_reg      <= 1'b0;
            len_reg       <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            box_valid_reg <= box_valid_next;
            many_reg      <= many_next;
            len_reg       <= len_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // box coordinates and result payload, no reset
    always_ff @(posedge clk)
    begin
        box_row_reg <= box_row_next;
        box_col_reg <= box_col_next;
        if (fire && stage_ctrl.last)
        begin
            path_len_reg <= path_len_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign path_len  = path_len_reg;

    // a last track always lands in the result register
    assert property (@(posedge clk) disable iff (!rst_n)
        fire && stage_ctrl.last |=> out_valid_reg)
        else $error("result missing after last track");

    // a completed path leaves no state behind
    assert property (@(posedge clk) disable iff (!rst_n)
        fire && stage_ctrl.last |=> (count_reg == '0) && (len_reg == '0))
        else $error("path state not cleared");

    // an empty path has no group and no shared boxes
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> !many_reg && (box_valid_reg == 2'b00))
        else $error("group state without tracks");

    // a running group always keeps at least one shared box
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0) |-> (box_valid_reg != 2'b00))
        else $error("open group with empty box set");

    // non-final tracks count up until saturation
    assert property (@(posedge clk) disable iff (!rst_n)
        fire && !stage_ctrl.last && (count_reg != COUNT_MAX)
        |=> count_reg == $past(count_reg) + COUNT_BITS'(1))
        else $error("track count did not advance");

endmodule

`default_nettype wire

/* rtl/routed_track_path_length.sv */
// Routed track path length: top level with the mode register.
// A track passes from the input register to the path state; on a last track
// path_len is then registered in the result register once that register can take it.
// Throughput: one track per cycle, unless a last track waits on a full result register that is not being read.
// Reset (rst_n low, asynchronous) clears the path state, both valid flags
// and count_every_track; a new path then starts with the next track.
`default_nettype none

module routed_track_path_length #(
    parameter int COORD_BITS = 10,
    parameter int COUNT_BITS = 16
) (
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire                            in_valid,
    output logic                           in_ready,
    input  wire  [COORD_BITS-1:0]          track_row,
    input  wire  [COORD_BITS-1:0]          track_col,
    input  wire                            track_vertical,
    input  wire                            last_track,
    output logic                           out_valid,
    input  wire                            out_ready,
    output logic [rtpl_pkg::LEN_BITS-1:0]  path_len,
    input  wire                            cfg_valid,
    output logic                           cfg_ready,
    input  wire                            cfg_data
);

    logic                  count_every_track_reg;
    logic                  count_every_track_next;
    logic                  take;
    logic                  stage_valid;
    logic [COORD_BITS-1:0] stage_row;
    logic [COORD_BITS-1:0] stage_col;
    rtpl_pkg::track_ctrl_t stage_ctrl;

    // mode register, always writable
    assign cfg_ready              = 1'b1;
    assign count_every_track_next = cfg_valid ? cfg_data : count_every_track_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_every_track_reg <= 1'b0;
        end
        else
        begin
            count_every_track_reg <= count_every_track_next;
        end
    end

    // input register
    rtpl_track_stage #(
        .COORD_BITS (COORD_BITS)
    ) u_stage (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .track_row      (track_row),
        .track_col      (track_col),
        .track_vertical (track_vertical),
        .last_track     (last_track),
        .take           (take),
        .stage_valid    (stage_valid),
        .stage_row      (stage_row),
        .stage_col      (stage_col),
        .stage_ctrl     (stage_ctrl)
    );

    // path state and result register
    rtpl_length_core #(
        .COORD_BITS (COORD_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .clk               (clk),
        .rst_n             (rst_n),
        .stage_valid       (stage_valid),
        .stage_row         (stage_row),
        .stage_col         (stage_col),
        .stage_ctrl        (stage_ctrl),
        .count_every_track (count_every_track_reg),
        .take              (take),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .path_len          (path_len)
    );

endmodule

`default_nettype wire

/* dv/testbench.sv */
// self-checking testbench for the routed track path length block
module testbench;

    localparam int COORD_BITS = 10;
    localparam int COUNT_BITS = 16;
    localparam int QUIET_LIMIT = 5000;
    localparam int HOLD_CYCLES = 300;
    localparam int RANDOM_PHASES = 5;
    localparam int TRACKS_PER_PHASE = 90;

    typedef logic [COORD_BITS-1:0] coord_t;
    typedef logic [rtpl_pkg::LEN_BITS-1:0] len_t;

    // one switch box touched by a track
    typedef struct {
        coord_t row;
        coord_t col;
        bit     ok;
    } sw_box_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    coord_t             track_row;
    coord_t             track_col;
    logic               track_vertical;
    logic               last_track;
    logic               out_valid;
    logic               out_ready;
    len_t               path_len;
    logic               cfg_valid;
    logic               cfg_ready;
    logic               cfg_data;

    // path length predictor state
    sw_box_t                 shared_boxes [2];
    bit                      group_many = 1'b0;
    len_t                    closed_len = '0;
    logic [COUNT_BITS-1:0]   tracks_seen = '0;
    bit                      every_track_mode = 1'b0;
    len_t                    expected_len_q [$];

    // run control and bookkeeping
    bit tx_gaps = 1'b1;
    bit rx_stalls = 1'b1;
    bit hold_req = 1'b0;
    int fails = 0;
    int tracks_sent = 0;
    int paths_checked = 0;
    int mode_writes = 0;

    routed_track_path_length #(
        .COORD_BITS (COORD_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .track_row      (track_row),
        .track_col      (track_col),
        .track_vertical (track_vertical),
        .last_track     (last_track),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .path_len       (path_len),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // coordinate with extra weight on both ends of the grid
    function automatic coord_t rand_coord();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return coord_t'($urandom);
    endfunction

    function automatic bit box_hit(sw_box_t x, sw_box_t a, sw_box_t b);
        return (a.ok && a.row == x.row && a.col == x.col) ||
               (b.ok && b.row == x.row && b.col == x.col);
    endfunction

    // update the shared box set for one track, queue the length on a last track
    function automatic void predict_track(coord_t row, coord_t col, bit vertical, bit last);
        sw_box_t          own;
        sw_box_t          side;
        bit               any_left;
        longint unsigned  wide;
        int               i;
        own = '{row, col, 1'b1};
        side = '{row, col, 1'b0};
        if (!vertical && col != 0)
        begin
            side.col = col - 1'b1;
            side.ok = 1'b1;
        end
        if (vertical && row != 0)
        begin
            side.row = row - 1'b1;
            side.ok = 1'b1;
        end
        if (tracks_seen == 0)
        begin
            shared_boxes[0] = own;
            shared_boxes[1] = side;
            group_many = 1'b0;
        end
        else
        begin
            any_left = 1'b0;
            for (i = 0; i < 2; i++)
            begin
                if (shared_boxes[i].ok && !box_hit(shared_boxes[i], own, side))
                    shared_boxes[i].ok = 1'b0;
                any_left |= shared_boxes[i].ok;
            end
            // no box left in common: close the group and open a new one
            if (!any_left)
            begin
                wide = closed_len + rtpl_pkg::GROUP_STEP;
                closed_len = (wide > rtpl_pkg::LEN_MAX) ? rtpl_pkg::LEN_MAX : len_t'(wide);
                shared_boxes[0] = own;
                shared_boxes[1] = side;
                group_many = 1'b0;
            end
            else
                group_many = 1'b1;
        end
        if (tracks_seen != '1)
            tracks_seen++;
        if (last)
        begin
            if (every_track_mode || tracks_seen <= rtpl_pkg::SHORT_PATH)
                wide = tracks_seen;
            else
                wide = closed_len + (group_many ? rtpl_pkg::GROUP_STEP
                                                : rtpl_pkg::SINGLE_STEP);
            expected_len_q.push_back((wide > rtpl_pkg::LEN_MAX) ? rtpl_pkg::LEN_MAX
                                                                : len_t'(wide));
            // path done, back to an empty path
            shared_boxes[0].ok = 1'b0;
            shared_boxes[1].ok = 1'b0;
            group_many = 1'b0;
            closed_len = '0;
            tracks_seen = '0;
        end
    endfunction

    // offer one track and wait for its transaction
    task automatic send_track(coord_t row, coord_t col, bit vertical, bit last);
        int gap;
        gap = tx_gaps ? pick_gap() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        track_row <= row;
        track_col <= col;
        track_vertical <= vertical;
        last_track <= last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_track(row, col, vertical, last);
        tracks_sent++;
    endtask

    // drop valid, let every pending length come out, then let the pipeline settle
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_len_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // write count_every_track through the config channel
    task automatic write_mode(bit value);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        every_track_mode = value;
        mode_writes++;
    endtask

    // one path as a walk where most tracks touch a box of the previous one
    task automatic send_random_path(int n);
        coord_t r;
        coord_t c;
        bit     v;
        int     k;
        int     pick;
        r = rand_coord();
        c = rand_coord();
        v = 1'($urandom_range(0, 1));
        for (k = 0; k < n; k++)
        begin
            send_track(r, c, v, k == n - 1);
            pick = $urandom_range(0, 9);
            if (pick < 2)
            begin
                r = rand_coord();
                c = rand_coord();
                v = 1'($urandom_range(0, 1));
            end
            else if (pick > 2)
            begin
                // move to the side box, then to a track that touches it
                if ($urandom_range(0, 1))
                begin
                    if (v)
                        r = r - 1'b1;
                    else
                        c = c - 1'b1;
                end
                v = 1'($urandom_range(0, 1));
                if ($urandom_range(0, 1))
                begin
                    if (v)
                        r = r + 1'b1;
                    else
                        c = c + 1'b1;
                end
            end
        end
    endtask

    // grid extremes, short paths, chains, shared pairs and mode change mid-path
    task automatic run_directed_paths();
        tx_gaps = 1'b1;
        rx_stalls = 1'b1;
        send_track('0, '0, 1'b0, 1'b1);
        send_track('1, '1, 1'b1, 1'b1);
        send_track('0, '0, 1'b1, 1'b0);
        send_track('1, '1, 1'b0, 1'b1);
        // horizontal chain, the third track breaks the group
        send_track(10'd5, 10'd5, 1'b0, 1'b0);
        send_track(10'd5, 10'd6, 1'b0, 1'b0);
        send_track(10'd5, 10'd7, 1'b0, 1'b1);
        // same track repeated keeps both boxes shared
        send_track(10'd3, 10'd3, 1'b1, 1'b0);
        send_track(10'd3, 10'd3, 1'b1, 1'b0);
        send_track(10'd3, 10'd3, 1'b1, 1'b1);
        // fully disjoint tracks
        send_track('0, '0, 1'b1, 1'b0);
        send_track(10'd600, 10'd600, 1'b0, 1'b0);
        send_track('1, '0, 1'b1, 1'b1);
        // top row vertical has only its own box
        send_track('0, 10'd5, 1'b1, 1'b0);
        send_track('0, 10'd5, 1'b0, 1'b0);
        send_track(10'd1, 10'd5, 1'b1, 1'b1);
        // switch to count mode in the middle of a path
        send_track(10'd9, 10'd9, 1'b0, 1'b0);
        send_track(10'd9, 10'd10, 1'b0, 1'b0);
        wait_idle();
        write_mode(1'b1);
        send_track(10'd9, 10'd11, 1'b0, 1'b1);
        // and back to the grouped rule in the middle of a path
        send_track(10'd9, 10'd9, 1'b1, 1'b0);
        send_track(10'd10, 10'd9, 1'b1, 1'b0);
        wait_idle();
        write_mode(1'b0);
        send_track(10'd9, 10'd9, 1'b0, 1'b1);
        wait_idle();
    endtask

    // receiver holds off for a long stretch while one-track paths keep coming
    task automatic run_output_holdoff();
        int k;
        tx_gaps = 1'b0;
        hold_req = 1'b1;
        for (k = 0; k < 40; k++)
            send_track(rand_coord(), rand_coord(), 1'($urandom_range(0, 1)), 1'b1);
        tx_gaps = 1'b1;
        wait_idle();
    endtask

    // random walks in both modes, with and without idling
    task automatic run_random_paths();
        int p;
        int sent;
        int n;
        for (p = 0; p < RANDOM_PHASES; p++)
        begin
            write_mode(p == 1 || p == 3);
            tx_gaps = (p != 2);
            rx_stalls = (p != 2 && p != 4);
            sent = 0;
            while (sent < TRACKS_PER_PHASE)
            begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 40)
                                                 : $urandom_range(1, 10);
                send_random_path(n);
                sent += n;
            end
            wait_idle();
        end
        tx_gaps = 1'b1;
        rx_stalls = 1'b1;
    endtask

    // receiver ready: random stalls, plus one long hold when asked
    initial
    begin : result_ready
        int span;
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_ready <= 1'b0;
                span = HOLD_CYCLES;
            end
            else if (rx_stalls && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                span = pick_gap() + 1;
            end
            else
            begin
                out_ready <= 1'b1;
                span = $urandom_range(1, 12);
            end
            repeat (span) @(posedge clk);
        end
    end

    // compare each result transaction with the oldest expected length
    initial
    begin : result_check
        len_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                paths_checked++;
                if (expected_len_q.size() == 0)
                begin
                    fails++;
                    if (fails <= 10)
                        $display("unexpected path_len %0d with no path pending", path_len);
                end
                else
                begin
                    want = expected_len_q.pop_front();
                    if (path_len !== want)
                    begin
                        fails++;
                        if (fails <= 10)
                            $display("path_len mismatch: expected %0d, got %0d", want, path_len);
                    end
                end
            end
        end
    end

    // end the run if no transaction happens for too long
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout: no transaction for %0d cycles", quiet);
        $display("Verification failed");
        $finish;
    end

    // test sequence
    initial
    begin
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        track_row <= '0;
        track_col <= '0;
        track_vertical <= 1'b0;
        last_track <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed_paths();
        run_output_holdoff();
        run_random_paths();
        wait_idle();
        repeat (8) @(posedge clk);
        fails += expected_len_q.size();
        $display("sent %0d tracks, checked %0d path lengths, %0d mode writes",
                 tracks_sent, paths_checked, mode_writes);
        $display("covered grid edges, both modes, mid-path mode changes, short and long"
                 , " paths and a long output hold");
        if (fails == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

/* routed_track_path_length.f */
rtl/rtpl_pkg.sv
rtl/rtpl_track_stage.sv
rtl/rtpl_length_core.sv
rtl/routed_track_path_length.sv
dv/testbench.sv
